FILE: sv/isg_pkg.sv
// Package: payload types, register indexes, command codes and constants of the idle state governor.
`default_nettype none
package isg_pkg;

    // Fixed sizes of the platform state tables
    localparam int TABLE_ENTRIES = 4;
    localparam int ENTRY_W       = 16;
    localparam int STATE_W       = 2;
    localparam int IDX_W         = 3;

    // Parameter defaults
    localparam int MAX_STATES_DEF  = 4;
    localparam int FIRST_STATE_DEF = 0;

    // Expected time conversion
    localparam int NS_SHIFT   = 3;
    localparam int FAST_SHIFT = 7;
    localparam int US_DIVISOR = 125;
    localparam int FUZZ_US    = 4;

    // Divide by 125 as a reciprocal multiply: ceil(2^35 / 125), exact for 32-bit dividends
    localparam int DIV_W       = 32;
    localparam int RECIP_W     = 29;
    localparam int PROD_W      = DIV_W + RECIP_W;
    localparam int RECIP_SHIFT = 35;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 29'h1062_4DD3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATE_COUNT     = 3'd0,
        CFG_DEEPEST_USER    = 3'd1,
        CFG_DEEPEST_KERNEL  = 3'd2,
        CFG_RESIDENCY_TABLE = 3'd3,
        CFG_LATENCY_TABLE   = 3'd4,
        CFG_TIME_VALID_MASK = 3'd5,
        CFG_TICK_US         = 3'd6
    } isg_cfg_idx_t;

    localparam logic CMD_SELECT  = 1'b0;
    localparam logic CMD_REFLECT = 1'b1;

    typedef struct packed {
        logic        command;
        logic [47:0] sleep_length_ns;
        logic [47:0] extra_length_ns;
        logic [30:0] lat_limit_us;
        logic [31:0] last_residency_us;
    } isg_in_t;

    typedef struct packed {
        logic [1:0]  chosen_state;
        logic [31:0] expected_time_us;
        logic [31:0] prediction_us;
    } isg_out_t;

    // Handshake between the sequencer and the divider
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
    } isg_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } isg_div_rsp_t;

endpackage
`default_nettype wire

FILE: sv/isg_div125.sv
// Divider by 125 for 32-bit dividends: one reciprocal multiply and a shift.
`default_nettype none
module isg_div125 (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire isg_pkg::isg_div_req_t req,
    output isg_pkg::isg_div_rsp_t      rsp
);
    import isg_pkg::*;

    logic [DIV_W-1:0]  dvd_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              busy_reg;
    logic              done_reg;

    // Control: load, multiply, then a one-cycle done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= req.start;
            done_reg <= busy_reg;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
        end
        if (busy_reg) begin
            prod_reg <= {{RECIP_W{1'b0}}, dvd_reg} * {{DIV_W{1'b0}}, RECIP_MUL};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = DIV_W'(prod_reg[PROD_W-1:RECIP_SHIFT]);

`ifndef NO_ASSERTIONS
    // Completion follows the multiply step
    a_done_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a multiply");

    // A restart is never asked for mid-run
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.start)
        else $error("divider restarted while busy");

    // Done lasts a single cycle
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("divider done held too long");
`endif
endmodule
`default_nettype wire

FILE: sv/idle_state_governor_unit.sv
// Top level of the idle state governor: sequencer, state walk and reflect accumulators.
//
// Usage: a select beat (command 0) carries the sleep and extra lengths in ns and a
// latency limit; the block works out the expected residency in us and picks the
// deepest idle state that meets the depth, residency and latency limits. A reflect
// beat (command 1) carries the measured residency; the block updates its
// accumulators and reports a prediction. Each input beat gives exactly one result beat.
// Channels: s_valid/s_ready/s_data in, m_valid/m_ready/m_data out, and a write-only
// register port cfg_valid/cfg_ready/cfg_index/cfg_data (always ready; write only when idle).
// Path from the accepting edge to m_valid: a select with a zero latency limit goes
// straight to the emit step, a reflect passes the reflect and update steps, and any
// other select passes the prepare and check steps, the divide by 125 when the shifted
// sum fits 32 bits, and the walk. The divider loads, then multiplies; the walk checks one state a cycle.
// One item is in work at a time: s_ready is high only when the sequencer is idle, so the
// next beat can be taken as soon as m_valid rises, while the finished result waits in
// the output register. If the receiver stalls, the sequencer holds the finished item
// until the output register is free. Reset (aresetn, synchronous, active low) restores
// the register defaults and clears all governor state; no clearing pass.
`default_nettype none
module idle_state_governor_unit #(
    parameter int MAX_STATES  = isg_pkg::MAX_STATES_DEF,
    parameter int FIRST_STATE = isg_pkg::FIRST_STATE_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire isg_pkg::isg_in_t                    s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output isg_pkg::isg_out_t                        m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [isg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [isg_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import isg_pkg::*;

    localparam int WALK_LIMIT = (MAX_STATES < TABLE_ENTRIES) ? MAX_STATES : TABLE_ENTRIES;
    localparam logic [IDX_W-1:0] LIMIT_W = IDX_W'(WALK_LIMIT);
    localparam logic [IDX_W-1:0] FIRST_W = IDX_W'(FIRST_STATE);
    localparam logic [IDX_W-1:0] START_W = IDX_W'(FIRST_STATE + 1);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_PREP = 8'b0000_0010,
        ST_CHK  = 8'b0000_0100,
        ST_DIV  = 8'b0000_1000,
        ST_WALK = 8'b0001_0000,
        ST_REFL = 8'b0010_0000,
        ST_RUPD = 8'b0100_0000,
        ST_EMIT = 8'b1000_0000
    } isg_state_t;

    function automatic logic [ENTRY_W-1:0] tab_entry(input logic [63:0] tab,
                                                     input logic [STATE_W-1:0] idx);
        return tab[ENTRY_W*idx +: ENTRY_W];
    endfunction

    // Configuration registers
    logic [2:0]  state_count_reg;
    logic [1:0]  deepest_user_reg;
    logic [1:0]  deepest_kernel_reg;
    logic [63:0] residency_table_reg;
    logic [63:0] latency_table_reg;
    logic [3:0]  time_valid_mask_reg;
    logic [19:0] tick_us_reg;

    // Governor state
    logic [STATE_W-1:0] last_state_reg;
    logic [31:0]        exp_time_reg;
    logic [31:0]        last_measured_reg;
    logic [31:0]        elapsed_reg;

    // Sequencer and work registers
    isg_state_t  state_reg;
    isg_in_t     item_reg;
    logic [45:0] v_reg;
    logic [IDX_W-1:0] walk_i_reg;
    logic [31:0] pred_reg;
    logic [31:0] measured_reg;
    logic [31:0] lhs_reg;
    logic [31:0] rhs_reg;
    logic        m_valid_reg;
    isg_out_t    m_data_reg;

    isg_div_req_t div_req;
    isg_div_rsp_t div_rsp;

    isg_div125 u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    logic        s_fire;
    logic        out_free;
    logic [48:0] len_sum;
    logic [IDX_W-1:0] count_lim;
    logic        walk_stop;
    logic [31:0] resid_sel;
    logic [32:0] acc_sum;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // Sum of lengths, shifted to units of 8 ns later
    assign len_sum = {1'b0, item_reg.sleep_length_ns} + {1'b0, item_reg.extra_length_ns};

    // Divider only when the shifted sum fits 32 bits
    assign div_req.start    = (state_reg == ST_CHK) && (v_reg[45:32] == '0);
    assign div_req.dividend = v_reg[31:0];

    // Walk: stop at the first state that breaks a limit
    assign count_lim = (state_count_reg > LIMIT_W) ? LIMIT_W : state_count_reg;
    always_comb begin
        walk_stop = (walk_i_reg >= count_lim)
                 || (walk_i_reg > FIRST_W + IDX_W'(deepest_user_reg))
                 || (walk_i_reg > FIRST_W + IDX_W'(deepest_kernel_reg))
                 || ({16'd0, tab_entry(residency_table_reg, walk_i_reg[STATE_W-1:0])}
                     > exp_time_reg)
                 || ({15'd0, tab_entry(latency_table_reg, walk_i_reg[STATE_W-1:0])}
                     > item_reg.lat_limit_us);
    end

    // Reflect: pick the trusted measurement and accumulate with saturation
    assign resid_sel = time_valid_mask_reg[last_state_reg] ? item_reg.last_residency_us
                                                           : {12'd0, tick_us_reg};
    assign acc_sum   = {1'b0, elapsed_reg} + {1'b0, resid_sel};

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_count_reg     <= 3'd4;
            deepest_user_reg    <= 2'd2;
            deepest_kernel_reg  <= 2'd2;
            residency_table_reg <= '0;
            latency_table_reg   <= '0;
            time_valid_mask_reg <= 4'hF;
            tick_us_reg         <= 20'd10000;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_STATE_COUNT:     state_count_reg     <= cfg_data[2:0];
                CFG_DEEPEST_USER:    deepest_user_reg    <= cfg_data[1:0];
                CFG_DEEPEST_KERNEL:  deepest_kernel_reg  <= cfg_data[1:0];
                CFG_RESIDENCY_TABLE: residency_table_reg <= cfg_data;
                CFG_LATENCY_TABLE:   latency_table_reg   <= cfg_data;
                CFG_TIME_VALID_MASK: time_valid_mask_reg <= cfg_data[3:0];
                CFG_TICK_US:         tick_us_reg         <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // Sequencer and governor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            last_state_reg    <= '0;
            exp_time_reg      <= '0;
            last_measured_reg <= '0;
            elapsed_reg       <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            // Output beat: raised from the emit step, dropped once taken
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_data.command == CMD_REFLECT) begin
                            state_reg <= ST_REFL;
                        end else if (s_data.lat_limit_us == '0) begin
                            last_state_reg <= '0;
                            state_reg      <= ST_EMIT;
                        end else begin
                            state_reg <= ST_PREP;
                        end
                    end
                end
                ST_PREP: state_reg <= ST_CHK;
                ST_CHK: begin
                    if (v_reg[45:32] != '0) begin
                        exp_time_reg <= (v_reg[45:39] != '0) ? '1 : v_reg[38:7];
                        state_reg    <= ST_WALK;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        exp_time_reg <= div_rsp.quotient;
                        state_reg    <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (walk_stop) begin
                        last_state_reg <= STATE_W'(walk_i_reg - 3'd1);
                        state_reg      <= ST_EMIT;
                    end
                end
                ST_REFL: state_reg <= ST_RUPD;
                ST_RUPD: begin
                    if (lhs_reg < rhs_reg) begin
                        last_measured_reg <= measured_reg;
                        elapsed_reg       <= '0;
                    end else begin
                        elapsed_reg <= measured_reg;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Work datapath
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_data;
            pred_reg <= '0;
        end
        if (state_reg == ST_PREP) begin
            v_reg <= len_sum[48:NS_SHIFT];
        end
        if (state_reg == ST_CHK || state_reg == ST_DIV) begin
            walk_i_reg <= START_W;
        end else if (state_reg == ST_WALK && !walk_stop) begin
            walk_i_reg <= walk_i_reg + 3'd1;
        end
        if (state_reg == ST_REFL) begin
            measured_reg <= acc_sum[32] ? '1 : acc_sum[31:0];
            lhs_reg      <= resid_sel + 32'(FUZZ_US);
            rhs_reg      <= exp_time_reg - {16'd0, tab_entry(latency_table_reg, last_state_reg)};
        end
        if (state_reg == ST_RUPD) begin
            pred_reg <= (measured_reg > last_measured_reg) ? measured_reg : last_measured_reg;
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_data_reg.chosen_state     <= last_state_reg;
            m_data_reg.expected_time_us <= exp_time_reg;
            m_data_reg.prediction_us    <= pred_reg;
        end
    end

`ifndef NO_ASSERTIONS
    // One item at a time: no new beat right after one is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("input taken while an item is in work");

    // A result appears only from the emit step
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result without emit step");

    // Divider results arrive only while the sequencer waits for them
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider result outside divide step");

    // Emit never overwrites a result the receiver has not taken
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && m_valid_reg && !m_ready) |=> (state_reg == ST_EMIT))
        else $error("emit left while output still full");
`endif
endmodule
`default_nettype wire
